[design/assert_macros.svh]
// Assertion macros shared by the RTL that checks itself.
// Needs nothing else; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

[design/tspe_pkg.sv]
// Shared types and constants of the touch pointer event core.
// No dependencies; used by every module of the block.
package tspe_pkg;

    localparam int RAW_W   = 12;
    localparam int FRAC    = 16;
    localparam int COORD_W = 20;
    localparam int OFS_W   = 18;
    localparam int GAIN_W  = 20;
    localparam int WIN_W   = 24;
    localparam int TIME_W  = 48;
    localparam int CLK_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Datapath widths, sized for the coarsest normalization (eight raw bits)
    localparam int NORM_W = 20;
    localparam int SUM_W  = 22;
    localparam int BX_W   = 26;
    localparam int AX_W   = 31;
    localparam int FX_W   = 41;

    localparam int DEAD_BAND = 655;

    localparam logic signed [COORD_W-1:0] COORD_MAX  = 20'h7FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN  = 20'h80000;
    localparam logic signed [COORD_W-1:0] HOLD_RESET = 20'hF0000;
    localparam logic signed [AX_W-1:0]    ONE_Q16    = 31'sd65536;
    localparam logic [CLK_W-1:0]          CLICK_MAX  = 8'hFF;
    localparam logic [CLK_W-1:0]          CLICK_ONE  = 8'd1;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET   = 20'sd65536;
    localparam logic [WIN_W-1:0]         WINDOW_RESET = 24'd500000;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    typedef enum logic [1:0] {
        EV_MOVE    = 2'd0,
        EV_RAW     = 2'd1,
        EV_PRESS   = 2'd2,
        EV_RELEASE = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_OFFSET     = 3'd0,
        CFG_X_GAIN       = 3'd1,
        CFG_X_CROSS      = 3'd2,
        CFG_Y_OFFSET     = 3'd3,
        CFG_Y_GAIN       = 3'd4,
        CFG_Y_CROSS      = 3'd5,
        CFG_CLICK_WINDOW = 3'd6,
        CFG_RAW_ENABLE   = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MB,
        F_MA,
        F_MF,
        F_DEC
    } t_fstate;

    typedef struct packed {
        logic signed [OFS_W-1:0]  x_offset;
        logic signed [GAIN_W-1:0] x_gain;
        logic signed [GAIN_W-1:0] x_cross;
        logic signed [OFS_W-1:0]  y_offset;
        logic signed [GAIN_W-1:0] y_gain;
        logic signed [GAIN_W-1:0] y_cross;
        logic [WIN_W-1:0]         click_window;
        logic                     raw_enable;
    } t_cal;

    // One classified sample: which events to send and what they carry
    typedef struct packed {
        logic                      do_move;
        logic                      do_raw;
        logic                      do_edge;
        logic                      down;
        logic                      prev_btn;
        logic [CLK_W-1:0]          clicks;
        logic signed [COORD_W-1:0] hx;
        logic signed [COORD_W-1:0] hy;
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

[design/touch_sample_to_pointer_events_core.sv]
// Flow: a pressed sample passes through the three chained multiply states (F_MB, F_MA, F_MF)
// and the classify state F_DEC; a released one goes straight to F_DEC, which holds while the
// queue is full. The back end picks up each job before its first event, then sends one event
// per cycle while the output is not stalled.
// Reset (synchronous, active low) restores the calibration defaults, empties the queue and
// output register, and parks the held position at minus one with the button up.
`include "assert_macros.svh"
// Top level: configuration registers, front end, job queue and back end.
// Depends on tspe_pkg, tspe_front, tspe_queue and tspe_back.
module touch_sample_to_pointer_events_core #(
    parameter int unsigned SWAP_AXES = 0,
    parameter int unsigned RAW_BITS  = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sample request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [tspe_pkg::RAW_W-1:0]            i_pos_x,
    input  logic [tspe_pkg::RAW_W-1:0]            i_pos_y,
    input  logic                                  i_pressed,
    input  logic [tspe_pkg::TIME_W-1:0]           i_time_us,
    // event request channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [1:0]                            o_event_kind,
    output logic signed [tspe_pkg::COORD_W-1:0]   o_coord_x,
    output logic signed [tspe_pkg::COORD_W-1:0]   o_coord_y,
    output logic                                  o_button,
    output logic [tspe_pkg::CLK_W-1:0]            o_clicks,
    output logic                                  o_last,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [tspe_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tspe_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    tspe_pkg::t_cal   r_cal;
    tspe_pkg::t_job   push_job, head_job;
    tspe_pkg::t_qstat qstat;
    logic             push, pop;

    // Calibration registers: the user must write them only while the block is idle, so
    // no shadowing is needed; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.x_offset     <= '0;
            r_cal.x_gain       <= tspe_pkg::GAIN_RESET;
            r_cal.x_cross      <= '0;
            r_cal.y_offset     <= '0;
            r_cal.y_gain       <= tspe_pkg::GAIN_RESET;
            r_cal.y_cross      <= '0;
            r_cal.click_window <= tspe_pkg::WINDOW_RESET;
            r_cal.raw_enable   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (tspe_pkg::t_cfg_idx'(i_cfg_index))
                tspe_pkg::CFG_X_OFFSET:     r_cal.x_offset     <= i_cfg_data[tspe_pkg::OFS_W-1:0];
                tspe_pkg::CFG_X_GAIN:       r_cal.x_gain       <= i_cfg_data[tspe_pkg::GAIN_W-1:0];
                tspe_pkg::CFG_X_CROSS:      r_cal.x_cross      <= i_cfg_data[tspe_pkg::GAIN_W-1:0];
                tspe_pkg::CFG_Y_OFFSET:     r_cal.y_offset     <= i_cfg_data[tspe_pkg::OFS_W-1:0];
                tspe_pkg::CFG_Y_GAIN:       r_cal.y_gain       <= i_cfg_data[tspe_pkg::GAIN_W-1:0];
                tspe_pkg::CFG_Y_CROSS:      r_cal.y_cross      <= i_cfg_data[tspe_pkg::GAIN_W-1:0];
                tspe_pkg::CFG_CLICK_WINDOW: r_cal.click_window <= i_cfg_data[tspe_pkg::WIN_W-1:0];
                tspe_pkg::CFG_RAW_ENABLE:   r_cal.raw_enable   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front end: normalize, calibrate, apply dead band, count clicks, and
    // push one job per sample that produces any event.
    tspe_front #(
        .SWAP_AXES (SWAP_AXES),
        .RAW_BITS  (RAW_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pressed  (i_pressed),
        .i_time_us  (i_time_us),
        .i_cal      (r_cal),
        .o_push     (push),
        .o_job      (push_job),
        .i_qstat    (qstat)
    );

    // Short queue lets the front run ahead while the output is stalled.
    tspe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (qstat)
    );

    // Back end: send move, raw, then press/release, marking the final one.
    tspe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_job),
        .i_qstat      (qstat),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_kind (o_event_kind),
        .o_coord_x    (o_coord_x),
        .o_coord_y    (o_coord_y),
        .o_button     (o_button),
        .o_clicks     (o_clicks),
        .o_last       (o_last)
    );

    // Decoded view of the offered event and of a taken sample request.
    logic ev_is_press, ev_is_edge, in_take;

    assign ev_is_press = o_out_valid && (o_event_kind == tspe_pkg::EV_PRESS);
    assign ev_is_edge  = o_out_valid
                         && (o_event_kind inside {tspe_pkg::EV_PRESS, tspe_pkg::EV_RELEASE});
    assign in_take     = i_in_valid && !o_in_stall;

    // A press or release always closes its sample's events.
    `ASSERT_IMPLIES(a_edge_last, i_clk, i_rst_n, ev_is_edge, o_last, "edge event not last")
    // A press reports the button down and a nonzero click count.
    `ASSERT_IMPLIES(a_press_clicks, i_clk, i_rst_n, ev_is_press, o_button && o_clicks != '0, "bad press")
    // Only press events carry a click count.
    `ASSERT_IMPLIES(a_clicks_zero, i_clk, i_rst_n, o_out_valid && !ev_is_press, o_clicks == '0, "stray clicks")
    // One sample at a time: the front end is busy right after an accept.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_take, o_in_stall, "back to back sample")

endmodule

[design/tspe_queue.sv]
// Two-entry job queue between the sample front end and the event back end.
// Depends on tspe_pkg.
module tspe_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tspe_pkg::t_job   i_job,
    input  logic             i_pop,
    output tspe_pkg::t_job   o_head,
    output tspe_pkg::t_qstat o_stat
);

    tspe_pkg::t_job r_mem [tspe_pkg::QDEPTH];

    logic [tspe_pkg::QPTR_W-1:0] r_wptr;
    logic [tspe_pkg::QPTR_W-1:0] r_rptr;
    logic [tspe_pkg::QPTR_W:0]   r_count;
    logic                        do_push;
    logic                        do_pop;

    localparam logic [tspe_pkg::QPTR_W-1:0] PTR_LAST = tspe_pkg::QPTR_W'(tspe_pkg::QDEPTH - 1);
    localparam logic [tspe_pkg::QPTR_W:0]   CNT_FULL = (tspe_pkg::QPTR_W + 1)'(tspe_pkg::QDEPTH);

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[design/tspe_front.sv]
// Front end: takes touch samples, runs the calibration multiplies and
// classifies each sample into a job. Depends on tspe_pkg.
module tspe_front #(
    parameter int unsigned SWAP_AXES = 0,
    parameter int unsigned RAW_BITS  = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [tspe_pkg::RAW_W-1:0]          i_pos_x,
    input  logic [tspe_pkg::RAW_W-1:0]          i_pos_y,
    input  logic                                i_pressed,
    input  logic [tspe_pkg::TIME_W-1:0]         i_time_us,
    input  tspe_pkg::t_cal                      i_cal,
    output logic                                o_push,
    output tspe_pkg::t_job                      o_job,
    input  tspe_pkg::t_qstat                    i_qstat
);

    localparam int CW = tspe_pkg::COORD_W;
    localparam int FW = tspe_pkg::FX_W;
    localparam logic signed [FW-1:0] SAT_HI = FW'(tspe_pkg::COORD_MAX);
    localparam logic signed [FW-1:0] SAT_LO = FW'(tspe_pkg::COORD_MIN);
    localparam logic signed [CW:0]   DB_HI  = (CW + 1)'(tspe_pkg::DEAD_BAND);
    localparam logic signed [CW:0]   DB_LO  = -DB_HI;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [FW-1:0] v);
        logic signed [CW-1:0] res;
        if (v > SAT_HI) begin
            res = tspe_pkg::COORD_MAX;
        end else if (v < SAT_LO) begin
            res = tspe_pkg::COORD_MIN;
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    tspe_pkg::t_fstate r_state, n_state;

    logic signed [tspe_pkg::SUM_W-1:0] r_sum_x, r_sum_y;
    logic signed [tspe_pkg::BX_W-1:0]  r_bx, r_by;
    logic signed [tspe_pkg::AX_W-1:0]  r_ax, r_ay;
    logic signed [CW-1:0]              r_x, r_y;
    logic signed [CW-1:0]              r_nx, r_ny;
    logic                              r_down;
    logic [tspe_pkg::TIME_W-1:0]       r_time;

    logic signed [CW-1:0]              r_held_x, r_held_y;
    logic                              r_was_down;
    logic [tspe_pkg::TIME_W-1:0]       r_press_time;
    logic [tspe_pkg::CLK_W-1:0]        r_tally;

    logic [tspe_pkg::RAW_W-1:0]        raw_a, raw_b;
    logic [tspe_pkg::RAW_W+tspe_pkg::FRAC-1:0] norm_a, norm_b;
    logic [tspe_pkg::NORM_W-1:0]       nx_u, ny_u;
    logic signed [tspe_pkg::SUM_W-1:0] sum_x, sum_y;

    logic signed [tspe_pkg::SUM_W+tspe_pkg::GAIN_W-1:0] prod_bx, prod_by;
    logic signed [tspe_pkg::BX_W+tspe_pkg::GAIN_W-1:0]  prod_ax, prod_ay;
    logic signed [tspe_pkg::BX_W+tspe_pkg::AX_W-1:0]    prod_fx, prod_fy;

    logic signed [CW:0]                dx, dy;
    logic                              snap, move, edge_seen, press, any_event;
    logic signed [CW-1:0]              fx, fy;
    logic [tspe_pkg::TIME_W:0]         win_end;
    logic                              win_hit;
    logic [tspe_pkg::CLK_W-1:0]        new_tally;
    logic                              accept, commit;

    // Normalize: raw reading scaled to Q16 by 2^RAW_BITS
    assign raw_a  = (SWAP_AXES != 0) ? i_pos_y : i_pos_x;
    assign raw_b  = (SWAP_AXES != 0) ? i_pos_x : i_pos_y;
    assign norm_a = {raw_a, {tspe_pkg::FRAC{1'b0}}} >> RAW_BITS;
    assign norm_b = {raw_b, {tspe_pkg::FRAC{1'b0}}} >> RAW_BITS;
    assign nx_u   = norm_a[tspe_pkg::NORM_W-1:0];
    assign ny_u   = norm_b[tspe_pkg::NORM_W-1:0];
    assign sum_x  = signed'({2'b00, nx_u}) + tspe_pkg::SUM_W'(i_cal.x_offset);
    assign sum_y  = signed'({2'b00, ny_u}) + tspe_pkg::SUM_W'(i_cal.y_offset);

    assign prod_bx = r_sum_x * i_cal.x_gain;
    assign prod_by = r_sum_y * i_cal.y_gain;
    assign prod_ax = r_by * i_cal.x_cross;
    assign prod_ay = r_bx * i_cal.y_cross;
    assign prod_fx = r_bx * r_ax;
    assign prod_fy = r_by * r_ay;

    // Dead band against the held position, then classify
    assign dx   = (CW + 1)'(r_x) - (CW + 1)'(r_held_x);
    assign dy   = (CW + 1)'(r_y) - (CW + 1)'(r_held_y);
    assign snap = r_was_down && (dx >= DB_LO) && (dx <= DB_HI)
                  && (dy >= DB_LO) && (dy <= DB_HI);
    assign fx   = snap ? r_held_x : r_x;
    assign fy   = snap ? r_held_y : r_y;
    assign move = r_down && ((fx != r_held_x) || (fy != r_held_y));
    assign edge_seen = (r_down != r_was_down);
    assign press     = r_down && !r_was_down;
    assign any_event = move || edge_seen;

    assign win_end   = {1'b0, r_press_time} + (tspe_pkg::TIME_W + 1)'(i_cal.click_window);
    assign win_hit   = win_end > {1'b0, r_time};
    assign new_tally = !win_hit ? tspe_pkg::CLICK_ONE :
                       (r_tally == tspe_pkg::CLICK_MAX) ? r_tally : r_tally + 1'b1;

    assign o_in_stall = (r_state != tspe_pkg::F_IDLE);
    assign accept     = (r_state == tspe_pkg::F_IDLE) && i_in_valid;
    assign o_push     = (r_state == tspe_pkg::F_DEC) && any_event && !i_qstat.full;
    assign commit     = o_push;

    always_comb begin
        o_job.do_move  = move;
        o_job.do_raw   = r_down && i_cal.raw_enable;
        o_job.do_edge  = edge_seen;
        o_job.down     = r_down;
        o_job.prev_btn = r_was_down;
        o_job.clicks   = press ? new_tally : '0;
        o_job.hx       = fx;
        o_job.hy       = fy;
        o_job.nx       = r_nx;
        o_job.ny       = r_ny;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tspe_pkg::F_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_pressed ? tspe_pkg::F_MB : tspe_pkg::F_DEC;
                end
            end
            tspe_pkg::F_MB: n_state = tspe_pkg::F_MA;
            tspe_pkg::F_MA: n_state = tspe_pkg::F_MF;
            tspe_pkg::F_MF: n_state = tspe_pkg::F_DEC;
            tspe_pkg::F_DEC: begin
                // hold until the queue has room
                if (!any_event || !i_qstat.full) begin
                    n_state = tspe_pkg::F_IDLE;
                end
            end
            default: n_state = tspe_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tspe_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sum_x <= sum_x;
            r_sum_y <= sum_y;
            r_nx    <= nx_u[tspe_pkg::NORM_W-1] ? tspe_pkg::COORD_MAX : signed'(nx_u);
            r_ny    <= ny_u[tspe_pkg::NORM_W-1] ? tspe_pkg::COORD_MAX : signed'(ny_u);
            r_down  <= i_pressed;
            r_time  <= i_time_us;
        end
        if (r_state == tspe_pkg::F_MB) begin
            r_bx <= prod_bx[tspe_pkg::FRAC +: tspe_pkg::BX_W];
            r_by <= prod_by[tspe_pkg::FRAC +: tspe_pkg::BX_W];
        end
        if (r_state == tspe_pkg::F_MA) begin
            r_ax <= tspe_pkg::ONE_Q16
                    + tspe_pkg::AX_W'(signed'(prod_ax[tspe_pkg::FRAC +: tspe_pkg::AX_W-1]));
            r_ay <= tspe_pkg::ONE_Q16
                    + tspe_pkg::AX_W'(signed'(prod_ay[tspe_pkg::FRAC +: tspe_pkg::AX_W-1]));
        end
        if (r_state == tspe_pkg::F_MF) begin
            r_x <= sat_coord(prod_fx[tspe_pkg::FRAC +: FW]);
            r_y <= sat_coord(prod_fy[tspe_pkg::FRAC +: FW]);
        end
    end

    // Pointer state advances only when the job is handed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x     <= tspe_pkg::HOLD_RESET;
            r_held_y     <= tspe_pkg::HOLD_RESET;
            r_was_down   <= 1'b0;
            r_press_time <= '0;
            r_tally      <= '0;
        end else if (commit) begin
            if (move) begin
                r_held_x <= fx;
                r_held_y <= fy;
            end
            r_was_down <= r_down;
            if (press) begin
                r_tally      <= new_tally;
                r_press_time <= r_time;
            end
        end
    end

endmodule

[design/tspe_back.sv]
// Back end: unpacks one queued job into up to three events and drives
// the registered output channel. Depends on tspe_pkg.
module tspe_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tspe_pkg::t_job                      i_head,
    input  tspe_pkg::t_qstat                    i_qstat,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_event_kind,
    output logic signed [tspe_pkg::COORD_W-1:0] o_coord_x,
    output logic signed [tspe_pkg::COORD_W-1:0] o_coord_y,
    output logic                                o_button,
    output logic [tspe_pkg::CLK_W-1:0]          o_clicks,
    output logic                                o_last
);

    // pending-event bits, in emission order
    localparam int P_MOVE = 0;
    localparam int P_RAW  = 1;
    localparam int P_EDGE = 2;

    tspe_pkg::t_job r_job;
    logic [2:0]     r_pend;
    logic           r_valid;
    tspe_pkg::t_kind r_kind;
    logic signed [tspe_pkg::COORD_W-1:0] r_cx, r_cy;
    logic           r_btn;
    logic [tspe_pkg::CLK_W-1:0] r_clicks;
    logic           r_last;

    logic           slot_free, emit, load;
    logic [2:0]     sel, rest;
    tspe_pkg::t_kind n_kind;
    logic signed [tspe_pkg::COORD_W-1:0] n_cx, n_cy;
    logic           n_btn;
    logic [tspe_pkg::CLK_W-1:0] n_clicks;

    assign slot_free = !r_valid || !i_out_stall;
    assign emit      = slot_free && (r_pend != '0);
    assign load      = (r_pend == '0) && !i_qstat.empty;
    assign o_pop     = load;
    assign rest      = r_pend & ~sel;

    always_comb begin
        sel      = '0;
        n_kind   = tspe_pkg::EV_MOVE;
        n_cx     = '0;
        n_cy     = '0;
        n_btn    = r_job.prev_btn;
        n_clicks = '0;
        if (r_pend[P_MOVE]) begin
            sel[P_MOVE] = 1'b1;
            n_cx        = r_job.hx;
            n_cy        = r_job.hy;
        end else if (r_pend[P_RAW]) begin
            sel[P_RAW] = 1'b1;
            n_kind     = tspe_pkg::EV_RAW;
            n_cx       = r_job.nx;
            n_cy       = r_job.ny;
        end else begin
            sel[P_EDGE] = 1'b1;
            n_kind      = r_job.down ? tspe_pkg::EV_PRESS : tspe_pkg::EV_RELEASE;
            n_btn       = r_job.down;
            n_clicks    = r_job.clicks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_pend[P_MOVE] <= i_head.do_move;
                r_pend[P_RAW]  <= i_head.do_raw;
                r_pend[P_EDGE] <= i_head.do_edge;
            end else if (emit) begin
                r_pend <= rest;
            end
            if (emit) begin
                r_valid <= 1'b1;
            end else if (slot_free) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_head;
        end
        if (emit) begin
            r_kind   <= n_kind;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_btn    <= n_btn;
            r_clicks <= n_clicks;
            r_last   <= (rest == '0);
        end
    end

    assign o_out_valid  = r_valid;
    assign o_event_kind = r_kind;
    assign o_coord_x    = r_cx;
    assign o_coord_y    = r_cy;
    assign o_button     = r_btn;
    assign o_clicks     = r_clicks;
    assign o_last       = r_last;

endmodule
